// ===== src/mchf_pkg.sv =====
// ============================================================================
// Multicast CRC hash filter package
// Shared constants, command codes and control structs for the filter table.
// ============================================================================
`default_nettype none

package mchf_pkg;

   localparam int ADDR_BYTES = 6;
   localparam int ADDR_BITS  = 8 * ADDR_BYTES;
   localparam int CRC_BITS   = 32;
   localparam int CNT_BITS   = $clog2(ADDR_BITS);
   localparam int SEL_BITS   = 5;

   localparam logic [CRC_BITS-1:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [CRC_BITS-1:0] CRC_INIT = 32'hFFFF_FFFF;

   // Operation codes carried in the func field of a request.
   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   // Commands from the sequencer to the serial CRC unit.
   typedef struct packed {
      logic load;
   } crc_ctrl_type;

   // Status from the serial CRC unit back to the sequencer.
   typedef struct packed {
      logic running;
      logic done;
   } crc_stat_type;

   // Commands from the sequencer to the filter table.
   typedef struct packed {
      logic                clear;
      logic                set;
      logic                word_sel;
      logic [SEL_BITS-1:0] bit_sel;
   } tbl_cmd_type;

   // Bit reversal of a CRC word; pure wiring.
   function automatic logic [CRC_BITS-1:0] reverse_crc(input logic [CRC_BITS-1:0] v);
      logic [CRC_BITS-1:0] r;
      for (int i = 0; i < CRC_BITS; i++) begin
         r[CRC_BITS-1-i] = v[i];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/multicast_crc_hash_filter_table.sv =====
// ============================================================================
// Multicast CRC hash filter table
// Top level: request sequencer, bit-serial CRC-32 unit and 64-bit filter.
// ============================================================================
//
// Usage
//   A request is taken on the rising edge where start is high and busy is
//   low. req_func selects an add (hash req_addr into the filter) or a
//   clear (zero both filter words; the address is ignored).
//   Every request gives exactly one response: rsp_valid is high for one
//   cycle and the rsp_ ports carry the hash, the selected word and bit, and
//   both filter words as they stand after the operation. The receiver
//   cannot stall; the response is gone after that one cycle.
// Timing
//   An add shifts the 48 address bits through the serial CRC register one
//   bit per cycle; hash and table bit are registered once the CRC unit
//   reports done, and the response follows. A clear is taken at the next
//   edge. busy is high from the request edge of an add until the response
//   cycle; a new request may be issued in the response cycle, so adds run
//   back to back and clears every cycle.
// Reset
//   Synchronous reset zeroes both filter words and returns the sequencer
//   to idle; no response is pending afterwards.
//
`default_nettype none

module multicast_crc_hash_filter_table (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output      logic                                 busy,
   input  wire logic                                 req_func,
   input  wire logic [mchf_pkg::ADDR_BITS-1:0]       req_addr,
   output      logic                                 rsp_valid,
   output      logic [mchf_pkg::CRC_BITS-1:0]        rsp_hash,
   output      logic                                 rsp_word_select,
   output      logic [mchf_pkg::SEL_BITS-1:0]        rsp_bit_select,
   output      logic [mchf_pkg::CRC_BITS-1:0]        rsp_table_low,
   output      logic [mchf_pkg::CRC_BITS-1:0]        rsp_table_high
);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [mchf_pkg::CRC_BITS-1:0] hash_ff, hash_in;
   logic                          accept;
   logic [mchf_pkg::CRC_BITS-1:0] crc;
   logic [mchf_pkg::CRC_BITS-1:0] crc_rev;
   mchf_pkg::crc_ctrl_type        crc_ctrl;
   mchf_pkg::crc_stat_type        crc_stat;
   mchf_pkg::tbl_cmd_type         tbl_cmd;

   assign busy   = (state_ff == ST_RUN);
   assign accept = start && !busy;

   assign crc_rev = mchf_pkg::reverse_crc(crc);

   // An add loads the CRC unit; the table bit is set and the hash captured on
   // the cycle the CRC unit reports done. A clear zeroes the table and hash.
   always_comb begin
      state_in         = state_ff;
      hash_in          = hash_ff;
      crc_ctrl.load    = 1'b0;
      tbl_cmd.clear    = 1'b0;
      tbl_cmd.set      = 1'b0;
      tbl_cmd.word_sel = crc_rev[31];
      tbl_cmd.bit_sel  = crc_rev[30:26];
      unique case (state_ff)
         ST_IDLE, ST_RESP: begin
            state_in = ST_IDLE;
            if (accept) begin
               if (req_func == mchf_pkg::FUNC_CLEAR) begin
                  tbl_cmd.clear = 1'b1;
                  hash_in       = '0;
                  state_in      = ST_RESP;
               end else begin
                  crc_ctrl.load = 1'b1;
                  state_in      = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (crc_stat.done) begin
               tbl_cmd.set = 1'b1;
               hash_in     = crc_rev;
               state_in    = ST_RESP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   mchf_crc_serial u_crc (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (crc_ctrl),
      .addr     (req_addr),
      .stat     (crc_stat),
      .crc      (crc)
   );

   mchf_table u_table (
      .clock      (clock),
      .reset      (reset),
      .cmd        (tbl_cmd),
      .table_low  (rsp_table_low),
      .table_high (rsp_table_high)
   );

   assign rsp_valid       = (state_ff == ST_RESP);
   assign rsp_hash        = hash_ff;
   assign rsp_word_select = hash_ff[31];
   assign rsp_bit_select  = hash_ff[30:26];

   // While the sequencer waits, the CRC unit must be shifting or reporting done.
   a_run_matches_crc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (crc_stat.running || crc_stat.done))
      else $error("sequencer waits while the CRC unit is idle");

   // An accepted add keeps the block busy on the following cycle.
   a_add_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == mchf_pkg::FUNC_ADD) |=> busy)
      else $error("add request did not start the CRC");

   // A clear responds on the next cycle with an empty table and zero hash.
   a_clear_response: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == mchf_pkg::FUNC_CLEAR) |=>
      (rsp_valid && rsp_table_low == '0 && rsp_table_high == '0 && rsp_hash == '0))
      else $error("clear response wrong");

   // A response lasts one cycle unless a clear follows right away.
   a_single_response: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !start) |=> !rsp_valid)
      else $error("response repeated");

endmodule

`default_nettype wire

// ===== src/mchf_crc_serial.sv =====
// ============================================================================
// Bit-serial CRC-32 unit
// Shifts the address in one bit per cycle, least significant bit of each
// byte first, and folds it into a reflected CRC-32 register.
// ============================================================================
`default_nettype none

module mchf_crc_serial (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire mchf_pkg::crc_ctrl_type             ctrl,
   input  wire logic [mchf_pkg::ADDR_BITS-1:0]     addr,
   output      mchf_pkg::crc_stat_type             stat,
   output      logic [mchf_pkg::CRC_BITS-1:0]      crc
);

   logic [mchf_pkg::ADDR_BITS-1:0] shift_ff, shift_in;
   logic [mchf_pkg::ADDR_BITS-1:0] load_bits;
   logic [mchf_pkg::CRC_BITS-1:0]  crc_ff, crc_in;
   logic [mchf_pkg::CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                           running_ff, running_in;
   logic                           done_ff, done_in;
   logic                           feedback;

   // Put the bytes in transmit order so that bit 0 of the shift register
   // always holds the next bit to go into the CRC.
   always_comb begin
      for (int b = 0; b < mchf_pkg::ADDR_BYTES; b++) begin
         for (int k = 0; k < 8; k++) begin
            load_bits[b*8 + k] = addr[8*(mchf_pkg::ADDR_BYTES-1-b) + k];
         end
      end
   end

   assign feedback = crc_ff[0] ^ shift_ff[0];

   always_comb begin
      shift_in   = shift_ff;
      crc_in     = crc_ff;
      cnt_in     = cnt_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      if (ctrl.load) begin
         shift_in   = load_bits;
         crc_in     = mchf_pkg::CRC_INIT;
         cnt_in     = '0;
         running_in = 1'b1;
      end else if (running_ff) begin
         shift_in = {1'b0, shift_ff[mchf_pkg::ADDR_BITS-1:1]};
         crc_in   = {1'b0, crc_ff[mchf_pkg::CRC_BITS-1:1]}
                    ^ (feedback ? mchf_pkg::CRC_POLY : '0);
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == mchf_pkg::CNT_BITS'(mchf_pkg::ADDR_BITS - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      crc_ff   <= crc_in;
      if (reset) begin
         cnt_ff     <= '0;
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         running_ff <= running_in;
         done_ff    <= done_in;
      end
   end

   assign stat.running = running_ff;
   assign stat.done    = done_ff;
   assign crc          = crc_ff;

endmodule

`default_nettype wire

// ===== src/mchf_table.sv =====
// ============================================================================
// Multicast filter table
// Two 32-bit filter words; sets one bit on an add, zeroes both on a clear.
// ============================================================================
`default_nettype none

module mchf_table (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mchf_pkg::tbl_cmd_type         cmd,
   output      logic [mchf_pkg::CRC_BITS-1:0] table_low,
   output      logic [mchf_pkg::CRC_BITS-1:0] table_high
);

   logic [mchf_pkg::CRC_BITS-1:0] word_ff [2];
   logic [mchf_pkg::CRC_BITS-1:0] word_in [2];

   always_comb begin
      word_in[0] = word_ff[0];
      word_in[1] = word_ff[1];
      if (cmd.clear) begin
         word_in[0] = '0;
         word_in[1] = '0;
      end else if (cmd.set) begin
         word_in[cmd.word_sel] = word_ff[cmd.word_sel]
                                 | (mchf_pkg::CRC_BITS'(1) << cmd.bit_sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff[0] <= '0;
         word_ff[1] <= '0;
      end else begin
         word_ff[0] <= word_in[0];
         word_ff[1] <= word_in[1];
      end
   end

   assign table_low  = word_ff[0];
   assign table_high = word_ff[1];

endmodule

`default_nettype wire

// ===== dv/tb_multicast_crc_hash_filter_table.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Multicast CRC hash filter table testbench
// Sends add and clear requests to the filter table and checks every response
// field against a CRC-32 hash predictor that keeps its own copy of the filter.
// A short table of directed requests runs first, then random requests in
// three pacing phases.
// ============================================================================

module tb_multicast_crc_hash_filter_table;

   // Reflected Ethernet CRC-32 polynomial and seed. The CRC register is not
   // inverted at the end, only bit-reversed.
   localparam logic [31:0] ETH_POLY  = 32'hEDB8_8320;
   localparam logic [31:0] CRC_SEED  = 32'hFFFF_FFFF;

   localparam int CLOCK_HALF   = 2;
   localparam int RESET_CYCLES = 8;
   // The drain at the end waits longer than an add takes to respond, so that
   // any stray response is still seen.
   localparam int DRAIN_CYCLES = 64;
   // Slowest correct run: about 820 adds, each waited out in full, plus sender
   // gaps now and then. The limit lies well above that.
   localparam int CYCLE_LIMIT  = 500_000;
   localparam int RANDOM_PER_PHASE = 270;
   localparam int DIRECTED_ROWS    = 17;
   localparam int HISTORY_DEPTH    = 16;

   // One response: the hash, its selectors and both filter words.
   typedef struct packed {
      logic [31:0] hash;
      logic        word_sel;
      logic [4:0]  bit_sel;
      logic [31:0] tbl_low;
      logic [31:0] tbl_high;
   } filter_rsp_type;

   localparam filter_rsp_type ZERO_RSP = '0;

   // One row of the directed table. Where has_typed is set, typed_rsp is the
   // response that is expected; otherwise the predictor supplies it.
   typedef struct packed {
      logic           func;
      logic [47:0]    addr;
      logic           has_typed;
      filter_rsp_type typed_rsp;
   } directed_row_type;

   logic        clock;
   logic        reset        = 1'b1;
   logic        start        = 1'b0;
   logic        req_func     = 1'b0;
   logic [47:0] req_addr     = '0;

   logic        busy;
   logic        rsp_valid;
   logic [31:0] rsp_hash;
   logic        rsp_word_select;
   logic [4:0]  rsp_bit_select;
   logic [31:0] rsp_table_low;
   logic [31:0] rsp_table_high;

   // Predictor state: the 64-bit filter as two words.
   logic [31:0] filter_words [2] = '{32'h0, 32'h0};

   filter_rsp_type   pending_rsps [$];
   logic [47:0]      added_addrs [$];
   directed_row_type directed_rows [DIRECTED_ROWS];

   int sender_idle_pct = 0;
   int error_count     = 0;
   int cycle_count     = 0;

   multicast_crc_hash_filter_table DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_addr        (req_addr),
      .rsp_valid       (rsp_valid),
      .rsp_hash        (rsp_hash),
      .rsp_word_select (rsp_word_select),
      .rsp_bit_select  (rsp_bit_select),
      .rsp_table_low   (rsp_table_low),
      .rsp_table_high  (rsp_table_high)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Applies one request to the predicted filter and returns the response it
   // should produce. The CRC runs over the address bytes first to last, each
   // byte least significant bit first.
   function automatic filter_rsp_type predict_filter_op(input logic func,
                                                        input logic [47:0] addr);
      filter_rsp_type rsp;
      logic [31:0]    crc_reg;
      logic [7:0]     octet;
      logic           feedback;
      rsp = ZERO_RSP;
      if (func == mchf_pkg::FUNC_CLEAR) begin
         filter_words[0] = '0;
         filter_words[1] = '0;
      end else begin
         crc_reg = CRC_SEED;
         for (int b = 5; b >= 0; b--) begin
            octet = addr[8*b +: 8];
            for (int k = 0; k < 8; k++) begin
               feedback = crc_reg[0] ^ octet[k];
               crc_reg  = (crc_reg >> 1) ^ (feedback ? ETH_POLY : 32'h0);
            end
         end
         for (int i = 0; i < 32; i++) begin
            rsp.hash[i] = crc_reg[31-i];
         end
         rsp.word_sel = rsp.hash[31];
         rsp.bit_sel  = rsp.hash[30:26];
         // Setting a bit that is already set leaves the word unchanged.
         filter_words[rsp.word_sel][rsp.bit_sel] = 1'b1;
      end
      rsp.tbl_low  = filter_words[0];
      rsp.tbl_high = filter_words[1];
      return rsp;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] expected,
                                input logic [31:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, expected, actual);
         error_count++;
      end
   endtask

   // Sends one request and waits for the edge that accepts it. The sender may
   // first idle; during a gap the address lines carry noise, which the block
   // must ignore while start is low. start is never lowered and raised in the
   // same step, so back-to-back requests keep it high.
   task automatic issue_request(input logic func, input logic [47:0] addr,
                                input logic has_typed, input filter_rsp_type typed_rsp);
      filter_rsp_type predicted;
      if (sender_idle_pct != 0 && $urandom_range(99) < 4) begin
         start    <= 1'b0;
         req_addr <= {16'($urandom_range(16'hFFFF)), $urandom};
         repeat ($urandom_range(60, 1)) @(posedge clock);
      end
      while ($urandom_range(99) < sender_idle_pct) begin
         start    <= 1'b0;
         req_addr <= {16'($urandom_range(16'hFFFF)), $urandom};
         @(posedge clock);
      end
      start    <= 1'b1;
      req_func <= func;
      req_addr <= addr;
      // busy only changes at a rising edge, so its value at the falling edge
      // is the one that the next rising edge sees.
      @(negedge clock);
      while (busy) begin
         @(negedge clock);
      end
      @(posedge clock);
      // Accepted at this edge. The predictor always advances, so the filter
      // copy stays right even when the expected response is typed in.
      predicted = predict_filter_op(func, addr);
      pending_rsps.push_back(has_typed ? typed_rsp : predicted);
      if (func == mchf_pkg::FUNC_ADD) begin
         added_addrs.push_back(addr);
         if (added_addrs.size() > HISTORY_DEPTH) begin
            void'(added_addrs.pop_front());
         end
      end
   endtask

   // Response checker. The receiver cannot stall, so every cycle with
   // rsp_valid high is one response, compared with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      filter_rsp_type expected;
      if (!reset && rsp_valid) begin
         if (pending_rsps.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual hash %h low %h high %h",
                     $time, rsp_hash, rsp_table_low, rsp_table_high);
            error_count++;
         end else begin
            expected = pending_rsps.pop_front();
            compare_field("hash", expected.hash, rsp_hash);
            compare_field("word_select", 32'(expected.word_sel), 32'(rsp_word_select));
            compare_field("bit_select", 32'(expected.bit_sel), 32'(rsp_bit_select));
            compare_field("table_low", expected.tbl_low, rsp_table_low);
            compare_field("table_high", expected.tbl_high, rsp_table_high);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_rsps.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int          pick;
      logic        func;
      logic [47:0] addr;

      // Directed table. Clears read back all zeros, whatever the address.
      // The remaining rows hit the address extremes, common multicast
      // prefixes and the case of a bit that is already set.
      directed_rows[0]  = '{mchf_pkg::FUNC_CLEAR, 48'h0000_0000_0000, 1'b1, ZERO_RSP};
      directed_rows[1]  = '{mchf_pkg::FUNC_ADD,   48'h0000_0000_0000, 1'b0, ZERO_RSP};
      directed_rows[2]  = '{mchf_pkg::FUNC_ADD,   48'hFFFF_FFFF_FFFF, 1'b0, ZERO_RSP};
      directed_rows[3]  = '{mchf_pkg::FUNC_ADD,   48'h0000_0000_0000, 1'b0, ZERO_RSP};
      directed_rows[4]  = '{mchf_pkg::FUNC_ADD,   48'hFFFF_FFFF_FFFF, 1'b0, ZERO_RSP};
      directed_rows[5]  = '{mchf_pkg::FUNC_ADD,   48'h0100_5E00_0001, 1'b0, ZERO_RSP};
      directed_rows[6]  = '{mchf_pkg::FUNC_ADD,   48'h0100_5E7F_FFFF, 1'b0, ZERO_RSP};
      directed_rows[7]  = '{mchf_pkg::FUNC_ADD,   48'h3333_0000_0001, 1'b0, ZERO_RSP};
      directed_rows[8]  = '{mchf_pkg::FUNC_ADD,   48'h3333_0000_0001, 1'b0, ZERO_RSP};
      directed_rows[9]  = '{mchf_pkg::FUNC_ADD,   48'hAAAA_AAAA_AAAA, 1'b0, ZERO_RSP};
      directed_rows[10] = '{mchf_pkg::FUNC_ADD,   48'h5555_5555_5555, 1'b0, ZERO_RSP};
      directed_rows[11] = '{mchf_pkg::FUNC_ADD,   48'h8000_0000_0000, 1'b0, ZERO_RSP};
      directed_rows[12] = '{mchf_pkg::FUNC_ADD,   48'h0000_0000_0001, 1'b0, ZERO_RSP};
      directed_rows[13] = '{mchf_pkg::FUNC_CLEAR, 48'hFFFF_FFFF_FFFF, 1'b1, ZERO_RSP};
      directed_rows[14] = '{mchf_pkg::FUNC_CLEAR, 48'h1234_5678_9ABC, 1'b1, ZERO_RSP};
      directed_rows[15] = '{mchf_pkg::FUNC_ADD,   48'h0100_0000_0000, 1'b0, ZERO_RSP};
      directed_rows[16] = '{mchf_pkg::FUNC_ADD,   48'hFFFF_FFFF_FFFF, 1'b0, ZERO_RSP};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct = 0;
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         issue_request(directed_rows[r].func, directed_rows[r].addr,
                       directed_rows[r].has_typed, directed_rows[r].typed_rsp);
      end

      // Random requests. Most are adds with multicast-looking or fully random
      // addresses; some repeat a recent address so that its bit is already
      // set, and a few clears keep the filter from saturating for good.
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 63 : 0;
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            func = mchf_pkg::FUNC_ADD;
            addr = {16'($urandom_range(16'hFFFF)), $urandom};
            if (pick < 3) begin
               func = mchf_pkg::FUNC_CLEAR;
            end else if (pick < 20 && added_addrs.size() != 0) begin
               addr = added_addrs[$urandom_range(added_addrs.size() - 1)];
            end else if (pick < 40) begin
               addr = {24'h01_005E, 1'b0, addr[22:0]};
            end else if (pick < 55) begin
               addr = {16'h3333, addr[31:0]};
            end
            issue_request(func, addr, 1'b0, ZERO_RSP);
         end
      end

      start <= 1'b0;
      while (pending_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/mchf_pkg.sv
src/mchf_crc_serial.sv
src/mchf_table.sv
src/multicast_crc_hash_filter_table.sv
dv/tb_multicast_crc_hash_filter_table.sv
